[hw/rtl/rgbm_pkg.sv]
`default_nettype none

package rgbm_pkg;

	// Geometry limits
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	// Field and counter widths
	localparam int CHAN_W    = 8;
	localparam int DIM_W     = 9;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int ADDR_W    = 13;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 3;

	// Line store: one byte word holds eight column bits, two row buffers
	localparam int WORDS_PER_ROW = MAX_WIDTH / 8;
	localparam int WORD_AW       = $clog2(WORDS_PER_ROW);
	localparam int LS_AW         = WORD_AW + 1;
	localparam int LS_DEPTH      = 2 * WORDS_PER_ROW;
	localparam int NBYTES_W      = WORD_AW + 1;

	// Stream payload widths
	localparam int S_TDATA_W = 4 * CHAN_W;
	localparam int M_TDATA_W = 24;

	// Reset values of the registers
	localparam logic [CHAN_W-1:0] THRESH_RST = 8'd2;
	localparam logic [DIM_W-1:0]  DIM_RST    = 9'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESH_RED   = 3'd0,
		REG_THRESH_GREEN = 3'd1,
		REG_THRESH_BLUE  = 3'd2,
		REG_THRESH_ALPHA = 3'd3,
		REG_PIXEL_FORMAT = 3'd4,
		REG_IMAGE_WIDTH  = 3'd5,
		REG_IMAGE_HEIGHT = 3'd6,
		REG_MIRROR_MODE  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] threshold_red;
		logic [CHAN_W-1:0] threshold_green;
		logic [CHAN_W-1:0] threshold_blue;
		logic [CHAN_W-1:0] threshold_alpha;
		logic              pixel_format;
		logic [DIM_W-1:0]  image_width;
		logic [DIM_W-1:0]  image_height;
		logic [MODE_W-1:0] mirror_mode;
	} cfg_t;

	// One finished row waiting to be packed
	typedef struct packed {
		logic                buf_sel;
		logic [DIM_W-1:0]    width;
		logic [NBYTES_W-1:0] nbytes;
		logic                mirror_lr;
		logic [ADDR_W-1:0]   addr_base;
		logic                last_img;
	} task_t;

	typedef struct packed {
		logic              en;
		logic [LS_AW-1:0]  addr;
		logic [7:0]        data;
	} ls_wr_t;

	typedef struct packed {
		logic             en;
		logic [LS_AW-1:0] addr_a;
		logic [LS_AW-1:0] addr_b;
	} ls_rd_t;

	typedef struct packed {
		logic en;
		logic buf_sel;
	} done_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_FORMAT
	} bk_state_t;

	// Zero or oversized dimension means the maximum
	function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] val,
	                                             input logic [DIM_W-1:0] max_val);
		logic [DIM_W-1:0] res;
		if (val == '0 || val > max_val) begin
			res = max_val;
		end else begin
			res = val;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/rgbm_line_store.sv]
`default_nettype none

module rgbm_line_store
	import rgbm_pkg::*;
(
	input  wire logic   clk,
	input  wire ls_wr_t wr,
	input  wire ls_rd_t rd,
	output logic [7:0]  rd_data_a,
	output logic [7:0]  rd_data_b
);

	logic [7:0] mem [LS_DEPTH];

	// Write one word of column bits
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Two registered read ports
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_a <= mem[rd.addr_a];
			rd_data_b <= mem[rd.addr_b];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/rgbm_task_fifo.sv]
`default_nettype none

module rgbm_task_fifo
	import rgbm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire task_t push_task,
	input  wire logic  pop,
	output logic       task_valid,
	output task_t      head_task
);

	task_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign task_valid = (count_q != 2'd0);
	assign head_task  = entry_q[rd_ptr_q];

	// Store pushed rows
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_task;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q != 2'd2)
		else $error("row queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("row queue underflow");

endmodule

`default_nettype wire

[hw/rtl/rgbm_front.sv]
`default_nettype none

module rgbm_front
	import rgbm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire done_t                done,
	output ls_wr_t                    ls_wr,
	output logic                      push,
	output task_t                     push_task
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             buf_q;
	logic [1:0]       busy_q;
	logic [7:0]       acc_q;

	logic [CHAN_W-1:0]        red, green, blue, alpha;
	logic                     pix_bit;
	logic                     accept;
	logic [7:0]               acc_next;
	logic [DIM_W-1:0]         eff_w, eff_h;
	logic [DIM_W-1:0]         w_m1, h_m1;
	logic                     row_end;
	logic                     last_img;
	logic [ROW_W-1:0]         row_sel;
	logic [ROW_W-1:0]         out_row;
	logic [DIM_W:0]           w_round;
	logic [NBYTES_W-1:0]      nbytes;
	logic [ROW_W+NBYTES_W-1:0] base_full;

	assign red   = s_tdata[7:0];
	assign green = s_tdata[15:8];
	assign blue  = s_tdata[23:16];
	assign alpha = s_tdata[31:24];

	// Hold input while the buffer being filled still drains
	assign s_tready = !busy_q[buf_q];
	assign accept   = s_tvalid && s_tready;

	// Classify the pixel
	assign pix_bit = (red > cfg.threshold_red) || (green > cfg.threshold_green) ||
	                 (blue > cfg.threshold_blue) ||
	                 (cfg.pixel_format && (alpha > cfg.threshold_alpha));

	// Row geometry
	always_comb begin
		eff_w    = eff_size(cfg.image_width, DIM_W'(MAX_WIDTH));
		eff_h    = eff_size(cfg.image_height, DIM_W'(MAX_HEIGHT));
		w_m1     = eff_w - 9'd1;
		h_m1     = eff_h - 9'd1;
		row_end  = {1'b0, col_q} >= w_m1;
		last_img = {1'b0, row_q} >= h_m1;
		row_sel  = ({1'b0, row_q} < eff_h) ? row_q : h_m1[ROW_W-1:0];
		out_row  = cfg.mirror_mode[1] ? (h_m1[ROW_W-1:0] - row_sel) : row_sel;
		w_round  = {1'b0, eff_w} + 10'd7;
		nbytes   = w_round[DIM_W-1:3];
		base_full = out_row * nbytes;
	end

	// Merge the pixel into the current word
	always_comb begin
		acc_next = acc_q;
		acc_next[col_q[2:0]] = pix_bit;
	end

	// Write a word when it fills or the row ends
	always_comb begin
		ls_wr.en   = accept && ((col_q[2:0] == 3'd7) || row_end);
		ls_wr.addr = {buf_q, col_q[COL_W-1:3]};
		ls_wr.data = acc_next;
	end

	// Hand a finished row to the packer
	always_comb begin
		push                = accept && row_end;
		push_task.buf_sel   = buf_q;
		push_task.width     = eff_w;
		push_task.nbytes    = nbytes;
		push_task.mirror_lr = cfg.mirror_mode[0];
		push_task.addr_base = base_full[ADDR_W-1:0];
		push_task.last_img  = last_img;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= acc_next;
		end
	end

	// Advance column, row and buffer; track buffers owned by the packer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			buf_q  <= 1'b0;
			busy_q <= 2'b00;
		end else begin
			if (accept) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= last_img ? '0 : row_q + 1'b1;
					buf_q <= ~buf_q;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (done.en) begin
				busy_q[done.buf_sel] <= 1'b0;
			end
			if (push) begin
				busy_q[buf_q] <= 1'b1;
			end
		end
	end

	a_stall_both_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(&busy_q) |-> !s_tready)
		else $error("pixel accepted while both row buffers are owned by the packer");

	a_done_on_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done.en |-> busy_q[done.buf_sel])
		else $error("packer released a buffer that was not handed over");

endmodule

`default_nettype wire

[hw/rtl/rgbm_back.sv]
`default_nettype none

module rgbm_back
	import rgbm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 task_valid,
	input  wire task_t                head_task,
	output logic                      pop,
	output ls_rd_t                    ls_rd,
	input  wire logic [7:0]           rd_data_a,
	input  wire logic [7:0]           rd_data_b,
	output done_t                     done,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,
	output logic                      m_tlast,
	output logic                      m_tuser
);

	bk_state_t          state_q, state_d;
	task_t              task_q;
	logic [WORD_AW-1:0] k_q;

	logic              m_tvalid_q;
	logic [7:0]        byte_q;
	logic [ADDR_W-1:0] addr_q;
	logic              last_row_q;
	logic              last_img_q;

	logic               load_out;
	logic               last_byte;
	logic [DIM_W-1:0]   k_pix;
	logic [DIM_W-1:0]   src_top;
	logic [WORD_AW-1:0] word_hi;
	logic [2:0]         bit_off;
	logic [DIM_W-1:0]   rem;
	logic [15:0]        pair;
	logic [15:0]        pair_sh;
	logic [7:0]         rev;
	logic [7:0]         mask;
	logic [7:0]         byte_val;
	logic [NBYTES_W-1:0] nb_m1;

	// Byte position within the row
	always_comb begin
		k_pix     = {1'b0, k_q, 3'b000};
		src_top   = task_q.width - 9'd1 - k_pix;
		word_hi   = src_top[COL_W-1:3];
		bit_off   = src_top[2:0];
		rem       = task_q.width - k_pix;
		nb_m1     = task_q.nbytes - 1'b1;
		last_byte = (k_q == nb_m1[WORD_AW-1:0]);
	end

	// Read addresses: one word straight, two neighboring words when mirrored
	always_comb begin
		ls_rd.addr_a = task_q.mirror_lr ? {task_q.buf_sel, word_hi} : {task_q.buf_sel, k_q};
		ls_rd.addr_b = {task_q.buf_sel, word_hi - 1'b1};
	end

	// Pack the byte, first pixel in the top bit
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			rev[i] = rd_data_a[7-i];
		end
		pair    = {rd_data_a, rd_data_b};
		pair_sh = pair >> ({1'b0, bit_off} + 4'd1);
		if (rem >= 9'd8) begin
			mask = 8'hFF;
		end else begin
			mask = ~(8'hFF >> rem[2:0]);
		end
		byte_val = (task_q.mirror_lr ? pair_sh[7:0] : rev) & mask;
	end

	// Sequencer: take a row, then read and format one byte at a time
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		ls_rd.en    = 1'b0;
		load_out    = 1'b0;
		done.en     = 1'b0;
		done.buf_sel = task_q.buf_sel;
		unique case (state_q)
			BK_IDLE: begin
				if (task_valid) begin
					pop     = 1'b1;
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (!m_tvalid_q || m_tready) begin
					ls_rd.en = 1'b1;
					state_d  = BK_FORMAT;
				end
			end
			BK_FORMAT: begin
				load_out = 1'b1;
				if (last_byte) begin
					done.en = 1'b1;
					state_d = BK_IDLE;
				end else begin
					state_d = BK_READ;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Row descriptor and byte counter
	always_ff @(posedge clk) begin
		if (pop) begin
			task_q <= head_task;
			k_q    <= '0;
		end else if (load_out && !last_byte) begin
			k_q <= k_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			byte_q     <= byte_val;
			addr_q     <= task_q.addr_base + ADDR_W'(k_q);
			last_row_q <= last_byte;
			last_img_q <= last_byte && task_q.last_img;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - ADDR_W - 8){1'b0}}, addr_q, byte_q};
	assign m_tlast  = last_row_q;
	assign m_tuser  = last_img_q;

	a_format_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_FORMAT |-> $past(ls_rd.en))
		else $error("byte formatted without a line store read");

	a_out_free_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !m_tvalid_q)
		else $error("output register overwritten before being taken");

endmodule

`default_nettype wire

[hw/rtl/rgb_threshold_to_packed_mono.sv]
// Color raster to packed 1-bit-per-pixel rows.
// Slave stream: one pixel per item in row order, tdata = red, green, blue, alpha
// (byte 0 up). A pixel is 1 when any channel exceeds its threshold; alpha takes
// part only when pixel_format is 1.
// Master stream: one packed byte per item, first pixel of the (optionally
// mirrored) row in bit 7, tlast on the final byte of a row, tuser on the final
// byte of the image; tdata carries the byte and its destination address.
// Configuration channel: cfg_index selects one of eight registers; always ready.
// Write it only between images or rows while no bytes are pending.
// Throughput: the front takes one pixel per cycle into a two-row line store
// while it is not stalled. The packer handles one byte at a time: a line store
// read state, then a format state that loads the output register.
// The front stalls only when both row buffers still wait for the packer.
// A stalled receiver holds the byte in the output register; the packer then
// waits while the front keeps filling the other buffer.
// Reset clears counters, queue and output valid and loads register defaults.
`default_nettype none

module rgb_threshold_to_packed_mono
	import rgbm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // red, green, blue, alpha
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,   // packed_byte, byte_address, zero pad
	output logic                      m_tlast,
	output logic                      m_tuser    // last_in_image
);

	cfg_t   cfg_q;
	ls_wr_t ls_wr;
	ls_rd_t ls_rd;
	done_t  done;
	task_t  push_task, head_task;
	logic   push, pop, task_valid;
	logic [7:0] rd_data_a, rd_data_b;

	assign cfg_ready = 1'b1;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_red   <= THRESH_RST;
			cfg_q.threshold_green <= THRESH_RST;
			cfg_q.threshold_blue  <= THRESH_RST;
			cfg_q.threshold_alpha <= THRESH_RST;
			cfg_q.pixel_format    <= 1'b1;
			cfg_q.image_width     <= DIM_RST;
			cfg_q.image_height    <= DIM_RST;
			cfg_q.mirror_mode     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESH_RED:   cfg_q.threshold_red   <= cfg_data[CHAN_W-1:0];
				REG_THRESH_GREEN: cfg_q.threshold_green <= cfg_data[CHAN_W-1:0];
				REG_THRESH_BLUE:  cfg_q.threshold_blue  <= cfg_data[CHAN_W-1:0];
				REG_THRESH_ALPHA: cfg_q.threshold_alpha <= cfg_data[CHAN_W-1:0];
				REG_PIXEL_FORMAT: cfg_q.pixel_format    <= cfg_data[0];
				REG_IMAGE_WIDTH:  cfg_q.image_width     <= cfg_data;
				REG_IMAGE_HEIGHT: cfg_q.image_height    <= cfg_data;
				REG_MIRROR_MODE:  cfg_q.mirror_mode     <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	rgbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.done      (done),
		.ls_wr     (ls_wr),
		.push      (push),
		.push_task (push_task)
	);

	rgbm_line_store u_line_store (
		.clk       (clk),
		.wr        (ls_wr),
		.rd        (ls_rd),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	rgbm_task_fifo u_task_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_task  (push_task),
		.pop        (pop),
		.task_valid (task_valid),
		.head_task  (head_task)
	);

	rgbm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_valid (task_valid),
		.head_task  (head_task),
		.pop        (pop),
		.ls_rd      (ls_rd),
		.rd_data_a  (rd_data_a),
		.rd_data_b  (rd_data_b),
		.done       (done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

`default_nettype wire
